>>> src/nqfs_pkg.sv
package nqfs_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_NONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic place;
    logic advance;
    logic backtrack;
    logic emit_first;
    logic emit_next;
    logic show_row;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad_size;
    logic done;
    logic exhausted;
    logic at_top;
    logic free;
    logic last;
  } dp_status_t;

endpackage

>>> src/nqfs_controller.sv
module nqfs_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic                 last_row,
  input  nqfs_pkg::dp_status_t status,
  output nqfs_pkg::dp_cmd_t    cmd
);

  nqfs_pkg::state_t state;
  nqfs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nqfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nqfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.bad_size ? nqfs_pkg::ST_NONE : nqfs_pkg::ST_SEARCH;
        end
      end
      nqfs_pkg::ST_SEARCH: begin
        if (status.done) begin
          state_next = nqfs_pkg::ST_EMIT;
        end else if (status.exhausted && status.at_top) begin
          state_next = nqfs_pkg::ST_NONE;
        end
      end
      nqfs_pkg::ST_EMIT: begin
        if (!out_stall && status.last) begin
          state_next = nqfs_pkg::ST_IDLE;
        end
      end
      nqfs_pkg::ST_NONE: begin
        if (!out_stall) begin
          state_next = nqfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nqfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    found     = 1'b0;
    last_row  = 1'b0;
    case (state)
      nqfs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      nqfs_pkg::ST_SEARCH: begin
        // One trial, placement or backtrack step per cycle
        if (status.done) begin
          cmd.emit_first = 1'b1;
        end else if (status.exhausted) begin
          cmd.backtrack = !status.at_top;
        end else if (status.free) begin
          cmd.place = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      nqfs_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        found         = 1'b1;
        last_row      = status.last;
        cmd.show_row  = 1'b1;
        cmd.emit_next = !out_stall && !status.last;
      end
      nqfs_pkg::ST_NONE: begin
        out_valid = 1'b1;
        last_row  = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> src/nqfs_datapath.sv
module nqfs_datapath #(
  parameter int unsigned LIMIT = 16
) (
  input  logic                 clk,
  input  logic [4:0]           board_size,
  output logic [3:0]           row_index,
  output logic [3:0]           queen_column,
  input  nqfs_pkg::dp_cmd_t    cmd,
  output nqfs_pkg::dp_status_t status
);

  localparam int unsigned RW = $clog2(LIMIT + 1);
  localparam int unsigned CW = $clog2(LIMIT);
  localparam int unsigned DN = 2 * LIMIT - 1;
  localparam int unsigned DW = $clog2(DN);
  localparam logic [RW:0] LIM_M1 = (RW + 1)'(LIMIT - 1);
  localparam logic [5:0]  LIM_6  = 6'(LIMIT);

  logic [RW-1:0]   n;
  logic [RW-1:0]   row;
  logic [RW-1:0]   trial;
  logic [LIMIT-1:0] col_taken;
  logic [DN-1:0]   dn_taken;
  logic [DN-1:0]   up_taken;
  logic [CW-1:0]   placed [LIMIT];

  logic [RW-1:0] brow;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] rd_col;
  logic [RW:0]   dn_sum;
  logic [RW:0]   up_sum;
  logic [RW:0]   bdn_sum;
  logic [RW:0]   bup_sum;
  logic [RW:0]   row_inc;

  // Diagonal indices for the trial square and for the square being lifted
  always_comb begin
    brow    = row - 1'b1;
    rd_addr = status.exhausted ? brow[CW-1:0] : row[CW-1:0];
    rd_col  = placed[rd_addr];
    dn_sum  = {1'b0, row} + LIM_M1 - {1'b0, trial};
    up_sum  = {1'b0, row} + {1'b0, trial};
    bdn_sum = {1'b0, brow} + LIM_M1 - (RW + 1)'(rd_col);
    bup_sum = {1'b0, brow} + (RW + 1)'(rd_col);
    row_inc = {1'b0, row} + 1'b1;
  end

  // Status toward the controller
  always_comb begin
    status.bad_size  = (board_size == 5'd0) || ({1'b0, board_size} > LIM_6);
    status.done      = (row == n);
    status.exhausted = (trial >= n);
    status.at_top    = (row == '0);
    status.free      = !col_taken[trial[CW-1:0]] && !dn_taken[dn_sum[DW-1:0]] &&
                       !up_taken[up_sum[DW-1:0]];
    status.last      = (row_inc == {1'b0, n});
  end

  // Result fields, zero outside a found row
  assign row_index    = cmd.show_row ? 4'(row) : 4'd0;
  assign queen_column = cmd.show_row ? 4'(rd_col) : 4'd0;

  // Search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n         <= RW'(board_size);
      row       <= '0;
      trial     <= '0;
      col_taken <= '0;
      dn_taken  <= '0;
      up_taken  <= '0;
    end else if (cmd.place) begin
      placed[row[CW-1:0]]          <= trial[CW-1:0];
      col_taken[trial[CW-1:0]]     <= 1'b1;
      dn_taken[dn_sum[DW-1:0]]     <= 1'b1;
      up_taken[up_sum[DW-1:0]]     <= 1'b1;
      row                          <= row + 1'b1;
      trial                        <= '0;
    end else if (cmd.advance) begin
      trial <= trial + 1'b1;
    end else if (cmd.backtrack) begin
      // Lift the queen of the row above and resume one column to its right
      col_taken[rd_col]          <= 1'b0;
      dn_taken[bdn_sum[DW-1:0]]  <= 1'b0;
      up_taken[bup_sum[DW-1:0]]  <= 1'b0;
      row                        <= brow;
      trial                      <= RW'(rd_col) + 1'b1;
    end else if (cmd.emit_first) begin
      row <= '0;
    end else if (cmd.emit_next) begin
      row <= row + 1'b1;
    end
  end

endmodule

>>> src/n_queens_first_solution_top.sv
// N-queens first-solution search.
// Input channel: board_size with in_valid / in_stall. An item is taken when
// in_valid is high and in_stall is low; in_stall stays high from the accepted
// item until its last result has been taken, so one board is worked at a time.
// Output channel: found, row_index, queen_column, last_row with out_valid /
// out_stall. A solved board gives one result per row, rows in ascending order,
// last_row set on the final one. A board with no solution, or a size of zero
// or above the supported limit, gives a single result with found low.
// After the load, the search makes one step per cycle (one column trial, one
// placement or one backtrack), set by the single-step search loop. The count
// of steps depends on the board size. After the search, results come out one
// per cycle while out_stall is low; a stalled result holds unchanged.
// Reset (rst, synchronous) returns the block to idle with no result pending;
// no clearing pass is needed, since every search starts from empty masks.
module n_queens_first_solution_top #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] board_size,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [3:0] row_index,
  output logic [3:0] queen_column,
  output logic       last_row
);

  localparam int unsigned LIMIT = (MAX_SIZE < 16) ? MAX_SIZE : 16;

  nqfs_pkg::dp_cmd_t    cmd;
  nqfs_pkg::dp_status_t status;

  nqfs_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .last_row  (last_row),
    .status    (status),
    .cmd       (cmd)
  );

  nqfs_datapath #(
    .LIMIT (LIMIT)
  ) u_dp (
    .clk          (clk),
    .board_size   (board_size),
    .row_index    (row_index),
    .queen_column (queen_column),
    .cmd          (cmd),
    .status       (status)
  );

`ifndef SYNTHESIS
  // Input side is open only when no result is pending
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while a result is pending");

  // A not-found result is alone and carries zero fields
  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (last_row && row_index == 4'd0 && queen_column == 4'd0))
    else $error("malformed not-found result");

  // Taking the final result frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_row) |=> !in_stall)
    else $error("input not reopened after final result");

  // Rows of a solution advance by one per taken result
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && found && !last_row) |=>
      (out_valid && found && row_index == $past(row_index) + 4'd1))
    else $error("row sequence broken");
`endif

endmodule
